/* rtl/sha256h_pkg.sv */
// Shared types and constants for the SHA-256 byte-stream hasher.
// Holds the sequencer states, the working-variable struct, the initial hash
// values and the round-constant table. No dependencies.
`timescale 1ns / 1ps

package sha256h_pkg;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PAD,
    S_ROUND,
    S_UPDATE,
    S_OUT
  } state_t;

  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
    logic [31:0] f;
    logic [31:0] g;
    logic [31:0] h;
  } work_t;

  // Element 0 is the first chaining word.
  localparam logic [7:0][31:0] SHA_IV = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam logic [7:0] PAD_MARK     = 8'h80;
  localparam logic [5:0] LEN_OFFSET   = 6'd56;
  localparam logic [5:0] LAST_OFFSET  = 6'd63;
  localparam logic [5:0] LAST_ROUND   = 6'd63;
  localparam logic [3:0] LEN_BYTES    = 4'd8;
  localparam logic [1:0] LAST_WORD_IX = 2'd3;

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h0;
    endcase
    return k;
  endfunction

endpackage

/* rtl/sha256_stream_hasher.sv */
// SHA-256 byte-stream hasher: one message byte per transfer, digest as four 64-bit words.
// A byte is taken whenever the sequencer is idle; the 64th byte of a block stalls input
// while the block is hashed (64 rounds on the shared round unit, then the chaining update).
// End of message: the pad bytes (9 to 72) are absorbed one at a time, each block filled
// by padding is hashed the same way, then the digest goes out in four output transfers.
// Synchronous reset loads the initial hash values and clears the byte count.
`timescale 1ns / 1ps

module sha256_stream_hasher (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  data_byte,
  input  logic        byte_valid,
  input  logic        end_of_message,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] digest_word,
  output logic [1:0]  word_index,
  output logic        last_word
);

  sha256h_pkg::state_t state, state_next;

  logic [7:0][31:0]   hv;
  sha256h_pkg::work_t work, work_next;
  logic [511:0]       blk;
  logic [31:0]        w_new;
  logic [63:0]        byte_count;
  logic [63:0]        len_reg;
  logic [3:0]         len_cnt;
  logic               mark_sent;
  logic               padding;
  logic [5:0]         rnd;
  logic [1:0]         widx;

  logic [5:0] offset;
  logic       in_fire, out_fire, absorb;
  logic [7:0] pad_byte, absorb_byte;
  logic [63:0] count_inc;

  assign offset    = byte_count[5:0];
  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign count_inc = byte_count + {63'd0, byte_valid};

  always_comb begin
    if (!mark_sent) begin
      pad_byte = sha256h_pkg::PAD_MARK;
    end else if (len_cnt == 4'd0 && offset != sha256h_pkg::LEN_OFFSET) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = len_reg[63:56];
    end
  end

  sha256h_round u_round (
    .cur   (work),
    .k     (sha256h_pkg::round_k(rnd)),
    .w0    (blk[511:480]),
    .w1    (blk[479:448]),
    .w9    (blk[223:192]),
    .w14   (blk[63:32]),
    .nxt   (work_next),
    .w_new (w_new)
  );

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      sha256h_pkg::S_IDLE: begin
        if (in_fire) begin
          if (byte_valid && offset == sha256h_pkg::LAST_OFFSET) begin
            state_next = sha256h_pkg::S_ROUND;
          end else if (end_of_message) begin
            state_next = sha256h_pkg::S_PAD;
          end
        end
      end
      sha256h_pkg::S_PAD: begin
        if (offset == sha256h_pkg::LAST_OFFSET) begin
          state_next = sha256h_pkg::S_ROUND;
        end
      end
      sha256h_pkg::S_ROUND: begin
        if (rnd == sha256h_pkg::LAST_ROUND) begin
          state_next = sha256h_pkg::S_UPDATE;
        end
      end
      sha256h_pkg::S_UPDATE: begin
        if (!padding) begin
          state_next = sha256h_pkg::S_IDLE;
        end else if (len_cnt == sha256h_pkg::LEN_BYTES) begin
          state_next = sha256h_pkg::S_OUT;
        end else begin
          state_next = sha256h_pkg::S_PAD;
        end
      end
      sha256h_pkg::S_OUT: begin
        if (out_fire && widx == sha256h_pkg::LAST_WORD_IX) begin
          state_next = sha256h_pkg::S_IDLE;
        end
      end
      default: state_next = sha256h_pkg::S_IDLE;
    endcase
  end

  // Outputs and strobes
  always_comb begin
    in_stall    = 1'b1;
    out_valid   = 1'b0;
    absorb      = 1'b0;
    absorb_byte = data_byte;
    case (state)
      sha256h_pkg::S_IDLE: begin
        in_stall = 1'b0;
        absorb   = in_valid && byte_valid;
      end
      sha256h_pkg::S_PAD: begin
        absorb      = 1'b1;
        absorb_byte = pad_byte;
      end
      sha256h_pkg::S_OUT: begin
        out_valid = 1'b1;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  assign digest_word = {hv[0], hv[1]};
  assign word_index  = widx;
  assign last_word   = (widx == sha256h_pkg::LAST_WORD_IX);

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= sha256h_pkg::S_IDLE;
      hv         <= sha256h_pkg::SHA_IV;
      byte_count <= 64'd0;
      len_cnt    <= 4'd0;
      mark_sent  <= 1'b0;
      padding    <= 1'b0;
      rnd        <= 6'd0;
      widx       <= 2'd0;
    end else begin
      state <= state_next;

      if (state == sha256h_pkg::S_IDLE && in_fire && end_of_message) begin
        padding <= 1'b1;
        len_reg <= {count_inc[60:0], 3'b000};
      end

      if (absorb) begin
        byte_count <= byte_count + 64'd1;
      end

      if (state == sha256h_pkg::S_PAD) begin
        if (!mark_sent) begin
          mark_sent <= 1'b1;
        end else if (len_cnt != 4'd0 || offset == sha256h_pkg::LEN_OFFSET) begin
          len_reg <= {len_reg[55:0], 8'h00};
          len_cnt <= len_cnt + 4'd1;
        end
      end

      // Block shift line doubles as the rolling schedule window
      if (absorb) begin
        blk <= {blk[503:0], absorb_byte};
      end else if (state == sha256h_pkg::S_ROUND) begin
        blk <= {blk[479:0], w_new};
      end

      // Working variable a takes chaining word 0
      if (state != sha256h_pkg::S_ROUND && state_next == sha256h_pkg::S_ROUND) begin
        work <= {hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]};
        rnd  <= 6'd0;
      end else if (state == sha256h_pkg::S_ROUND) begin
        work <= work_next;
        rnd  <= rnd + 6'd1;
      end

      if (state == sha256h_pkg::S_UPDATE) begin
        hv[0] <= hv[0] + work.a;
        hv[1] <= hv[1] + work.b;
        hv[2] <= hv[2] + work.c;
        hv[3] <= hv[3] + work.d;
        hv[4] <= hv[4] + work.e;
        hv[5] <= hv[5] + work.f;
        hv[6] <= hv[6] + work.g;
        hv[7] <= hv[7] + work.h;
      end

      if (out_fire) begin
        if (widx == sha256h_pkg::LAST_WORD_IX) begin
          // Digest delivered: back to the initial state
          hv         <= sha256h_pkg::SHA_IV;
          byte_count <= 64'd0;
          len_cnt    <= 4'd0;
          mark_sent  <= 1'b0;
          padding    <= 1'b0;
          widx       <= 2'd0;
        end else begin
          hv   <= {hv[1], hv[0], hv[7:2]};
          widx <= widx + 2'd1;
        end
      end
    end
  end

endmodule

/* rtl/sha256h_round.sv */
// One SHA-256 round and one message-schedule expansion step.
// Shared by all 64 rounds of a block; uses sha256h_pkg::work_t.
`timescale 1ns / 1ps

module sha256h_round (
  input  sha256h_pkg::work_t cur,
  input  logic [31:0]        k,
  input  logic [31:0]        w0,
  input  logic [31:0]        w1,
  input  logic [31:0]        w9,
  input  logic [31:0]        w14,
  output sha256h_pkg::work_t nxt,
  output logic [31:0]        w_new
);

  function automatic logic [31:0] rotr(input logic [31:0] x, input int unsigned r);
    return (x >> r) | (x << (32 - r));
  endfunction

  logic [31:0] big_s0, big_s1, ch, maj, t1, t2, sm0, sm1;

  always_comb begin
    big_s1 = rotr(cur.e, 6) ^ rotr(cur.e, 11) ^ rotr(cur.e, 25);
    big_s0 = rotr(cur.a, 2) ^ rotr(cur.a, 13) ^ rotr(cur.a, 22);
    ch     = (cur.e & cur.f) ^ (~cur.e & cur.g);
    maj    = (cur.a & cur.b) ^ (cur.a & cur.c) ^ (cur.b & cur.c);
    t1     = cur.h + big_s1 + ch + k + w0;
    t2     = big_s0 + maj;

    nxt.a = t1 + t2;
    nxt.b = cur.a;
    nxt.c = cur.b;
    nxt.d = cur.c;
    nxt.e = cur.d + t1;
    nxt.f = cur.e;
    nxt.g = cur.f;
    nxt.h = cur.g;

    // Word sixteen places ahead of the one consumed this round
    sm0   = rotr(w1, 7) ^ rotr(w1, 18) ^ (w1 >> 3);
    sm1   = rotr(w14, 17) ^ rotr(w14, 19) ^ (w14 >> 10);
    w_new = sm1 + w9 + sm0 + w0;
  end

endmodule
